// File: sv/frd_pkg.sv
// Package for the fraction reducer: word widths and transfer payload types.
package frd_pkg;

    localparam int WORD_BITS = 32;
    localparam int BOT_BITS  = WORD_BITS - 1;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef struct packed {
        logic signed [WORD_BITS-1:0] top_value;
        logic        [BOT_BITS-1:0]  bottom_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] reduced_top;
        logic        [BOT_BITS-1:0]  reduced_bottom;
        logic                        bad_bottom;
    } t_out_item;

endpackage

// File: sv/frd_divider.sv
// Restoring divider, one quotient bit per cycle; shared by all divisions.
module frd_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [frd_pkg::WORD_BITS-1:0]  i_dividend,
    input  logic [frd_pkg::BOT_BITS-1:0]   i_divisor,
    output logic                           o_done,
    output logic [frd_pkg::WORD_BITS-1:0]  o_quot,
    output logic [frd_pkg::BOT_BITS-1:0]   o_rem
);

    localparam int DW = frd_pkg::WORD_BITS;
    localparam int VW = frd_pkg::BOT_BITS;

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [frd_pkg::CNT_BITS-1:0]       r_cnt, n_cnt;
    logic [VW-1:0]                      r_rem, n_rem;
    logic [DW-1:0]                      r_quot, n_quot;
    logic [VW-1:0]                      r_div, n_div;
    logic [DW-1:0]                      w_trial;
    logic [DW-1:0]                      w_diff;
    logic                               w_ge;

    // remainder stays below the divisor, so the trial value fits DW bits
    assign w_trial = {r_rem, r_quot[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = frd_pkg::CNT_BITS'(DW);
            n_rem  = '0;
            n_quot = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
            n_quot = {r_quot[DW-2:0], w_ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == frd_pkg::CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: sv/fraction_reducer.sv
// Fraction reducer top level: Euclid gcd and reduction over one shared divider.
// Each division runs in the shared bit-serial divider: first the Euclid remainder steps,
//   then the numerator division, then the denominator division, after which the result is valid.
//   A zero denominator skips division: valid next cycle.
// One item at a time: the input is ready only when idle, so not before the last result is taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_out_valid.
module fraction_reducer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  frd_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output frd_pkg::t_out_item   o_out_data
);

    localparam int DW = frd_pkg::WORD_BITS;
    localparam int VW = frd_pkg::BOT_BITS;

    // sequencer: gcd loop, then numerator division, then denominator division
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIVT = 5'b00100,
        S_DIVB = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_neg, n_neg;
    logic [DW-1:0]        r_mag, n_mag;      // magnitude of the numerator
    logic [VW-1:0]        r_bot, n_bot;      // original denominator
    logic [VW-1:0]        r_b, n_b;          // current Euclid divisor, then the gcd
    logic signed [DW-1:0] r_qt, n_qt;        // signed reduced numerator
    frd_pkg::t_out_item   r_out, n_out;

    logic                 w_accept;
    logic [DW-1:0]        w_in_mag;
    logic                 w_start;
    logic [DW-1:0]        w_dividend;
    logic [VW-1:0]        w_divisor;
    logic                 w_done;
    logic [DW-1:0]        w_quot;
    logic [VW-1:0]        w_rem;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // the most negative value negates to itself, read as unsigned 2^(DW-1)
    assign w_in_mag   = i_in_data.top_value[DW-1] ? (DW'(0) - DW'(i_in_data.top_value))
                                                  : DW'(i_in_data.top_value);

    frd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state    = r_state;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_bot      = r_bot;
        n_b        = r_b;
        n_qt       = r_qt;
        n_out      = r_out;
        w_start    = 1'b0;
        w_dividend = r_mag;
        w_divisor  = r_b;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg = i_in_data.top_value[DW-1];
                    n_mag = w_in_mag;
                    n_bot = i_in_data.bottom_value;
                    n_b   = i_in_data.bottom_value;
                    if (i_in_data.bottom_value == '0) begin
                        // invalid denominator: pass inputs through, flag it
                        n_out.reduced_top    = i_in_data.top_value;
                        n_out.reduced_bottom = i_in_data.bottom_value;
                        n_out.bad_bottom     = 1'b1;
                        n_state              = S_OUT;
                    end else begin
                        w_start    = 1'b1;
                        w_dividend = w_in_mag;
                        w_divisor  = i_in_data.bottom_value;
                        n_state    = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (w_done) begin
                    w_start = 1'b1;
                    if (w_rem == '0) begin
                        // r_b is the gcd; reduce the numerator magnitude
                        w_dividend = r_mag;
                        w_divisor  = r_b;
                        n_state    = S_DIVT;
                    end else begin
                        w_dividend = DW'(r_b);
                        w_divisor  = w_rem;
                        n_b        = w_rem;
                    end
                end
            end
            S_DIVT: begin
                if (w_done) begin
                    n_qt       = r_neg ? $signed(DW'(0) - w_quot) : $signed(w_quot);
                    w_start    = 1'b1;
                    w_dividend = DW'(r_bot);
                    w_divisor  = r_b;
                    n_state    = S_DIVB;
                end
            end
            S_DIVB: begin
                if (w_done) begin
                    n_out.reduced_top    = r_qt;
                    n_out.reduced_bottom = w_quot[VW-1:0];
                    n_out.bad_bottom     = 1'b0;
                    n_state              = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_bot <= n_bot;
        r_b   <= n_b;
        r_qt  <= n_qt;
        r_out <= n_out;
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule
